>>> hw/rtl/gprk_pkg.sv
// Shared types and constants for the pad report to key word mapper.
`default_nettype none
package gprk_pkg;

  localparam int PORT_COUNT_DEF = 4;
  localparam int REPORT_LEN     = 37;
  localparam int STORE_DEPTH    = REPORT_LEN - 1;
  localparam int PORT_BYTES     = 9;
  localparam int CNT_MAX        = 63;
  localparam int AXIS_PEAK      = 85;
  localparam int AXIS_DIV       = 12700;
  localparam int DZ_SCALE       = 16129;
  localparam int RECIP_100      = 5243;
  localparam int RECIP_SHIFT    = 19;
  // floor(n / 12700) as (n * DIV_RECIP) >> DIV_SHIFT, exact for n < 3425000
  localparam int DIV_RECIP      = 2705492;
  localparam int DIV_SHIFT      = 35;

  localparam logic [6:0] DZ_RESET   = 7'd9;
  localparam logic [7:0] SENS_RESET = 8'd100;
  localparam logic [6:0] TRIG_RESET = 7'd50;
  localparam logic [6:0] CST_RESET  = 7'd40;

  typedef enum logic [1:0] {
    REG_DEADZONE    = 2'd0,
    REG_SENSITIVITY = 2'd1,
    REG_TRIGGER     = 2'd2,
    REG_CSTICK      = 2'd3
  } gprk_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL1,
    ST_MUL2,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } gprk_state_t;

  // floor(127 * pct / 100) by reciprocal, exact for pct < 128
  function automatic logic [7:0] pct_of_127(input logic [6:0] pct);
    logic [13:0] x;
    logic [26:0] p;
    x = {pct, 7'b0} - {7'b0, pct};
    p = {13'b0, x} * 27'(RECIP_100);
    return p[RECIP_SHIFT +: 8];
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/gamepad_report_to_keys_mapper.sv
// Top level: stores pad report bytes and turns each port into a key word.
`default_nettype none
// Report bytes are accepted one per cycle while the block is idle and written
// into a 36-byte report memory. On the byte flagged end_of_report the block
// stops taking bytes and produces PORT_COUNT key words, one after another.
// Each word is built in turn: ST_READ fetches the port's nine bytes through
// the memory's single read port, ST_MUL1 and ST_MUL2 multiply the stick
// values, ST_DIV divides the scaled stick value by 12700 with a reciprocal
// multiply, and ST_FIN forms the word, which is then held in the output
// register until taken. Byte input resumes after the last word is taken.
// A report of other than 37 bytes gives all-zero words with length_error set.
module gamepad_report_to_keys_mapper #(
  parameter int PORT_COUNT = gprk_pkg::PORT_COUNT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_report_byte,
  input  wire logic              in_end_of_report,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [7:0]        cfg_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             out_port_number,
  output logic                   out_port_present,
  output logic [15:0]            out_digital_buttons,
  output logic signed [7:0]      out_x_axis,
  output logic signed [7:0]      out_y_axis,
  output logic                   out_length_error,
  output logic                   out_last_port
);
  import gprk_pkg::*;

  gprk_state_t state_r, state_nxt;

  logic [6:0]  dz_r;
  logic [7:0]  sens_r;
  logic [6:0]  trig_r;
  logic [6:0]  cst_r;
  logic [7:0]  tthr_r;
  logic [7:0]  cthr_r;
  logic [20:0] dzlim_r;

  logic [7:0]  mem [STORE_DEPTH];
  logic [7:0]  rd_r;
  logic        rd_en;
  logic [5:0]  rd_addr;
  logic        wr_en;

  logic [5:0]  cnt_r;
  logic        bad_r;
  logic [1:0]  port_r;
  logic [5:0]  base_r;
  logic [3:0]  k_r;
  logic [7:0]  bytes_r [PORT_BYTES];

  logic        negx_r, negy_r;
  logic [15:0] px_r, py_r;
  logic        dzx_r, dzy_r;
  logic [21:0] remx_r, remy_r;
  logic [7:0]  qx_r, qy_r;

  logic        in_acc, out_acc, last_port;
  logic [7:0]  sx, sy;
  logic [7:0]  magx, magy;
  logic [21:0] nx, ny;
  logic [43:0] qpx, qpy;
  logic signed [9:0] cx, cy, cthr_s;
  logic [15:0] keys;
  logic signed [7:0] ax, ay;

  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign cfg_ready = 1'b1;
  assign last_port = (port_r == 2'(PORT_COUNT - 1));
  assign wr_en     = in_acc && (cnt_r >= 6'd1) && (cnt_r <= 6'(STORE_DEPTH));
  assign rd_addr   = base_r + {2'b0, k_r};

  // configuration and derived thresholds
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_r   <= DZ_RESET;
      sens_r <= SENS_RESET;
      trig_r <= TRIG_RESET;
      cst_r  <= CST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (gprk_reg_t'(cfg_index))
        REG_DEADZONE:    dz_r   <= cfg_data[6:0];
        REG_SENSITIVITY: sens_r <= cfg_data;
        REG_TRIGGER:     trig_r <= cfg_data[6:0];
        REG_CSTICK:      cst_r  <= cfg_data[6:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    tthr_r  <= pct_of_127(trig_r);
    cthr_r  <= pct_of_127(cst_r);
    dzlim_r <= 21'(dz_r) * 21'(DZ_SCALE);
  end

  // report memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[cnt_r - 6'd1] <= in_report_byte;
    if (rd_en) rd_r <= mem[rd_addr];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc && in_end_of_report) state_nxt = ST_READ;
      ST_READ: if (k_r == 4'(PORT_BYTES)) state_nxt = ST_MUL1;
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_DIV;
      ST_DIV:  state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_OUT;
      ST_OUT:  if (out_acc) state_nxt = last_port ? ST_IDLE : ST_READ;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    rd_en     = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready  = 1'b1;
      ST_READ: rd_en     = (k_r < 4'(PORT_BYTES));
      ST_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // byte counter and port sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      port_r <= '0;
      base_r <= '0;
      k_r    <= '0;
      bad_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        if (in_end_of_report) begin
          cnt_r  <= '0;
          bad_r  <= (cnt_r != 6'(REPORT_LEN - 1));
          port_r <= '0;
          base_r <= '0;
          k_r    <= '0;
        end else if (cnt_r != 6'(CNT_MAX)) begin
          cnt_r <= cnt_r + 6'd1;
        end
      end
      if (state_r == ST_READ) k_r <= k_r + 4'd1;
      if (state_r == ST_OUT && out_acc) begin
        port_r <= port_r + 2'd1;
        base_r <= base_r + 6'(PORT_BYTES);
        k_r    <= '0;
      end
    end
  end

  // stick magnitudes, raw ^ 0x80 as a signed byte
  assign sx    = {~bytes_r[3][7], bytes_r[3][6:0]};
  assign sy    = {~bytes_r[4][7], bytes_r[4][6:0]};
  assign magx  = sx[7] ? 8'(-sx) : sx;
  assign magy  = sy[7] ? 8'(-sy) : sy;
  assign nx    = 22'(px_r) * 22'(AXIS_PEAK);
  assign ny    = 22'(py_r) * 22'(AXIS_PEAK);
  assign qpx   = 44'(remx_r) * 44'(DIV_RECIP);
  assign qpy   = 44'(remy_r) * 44'(DIV_RECIP);

  // datapath
  always_ff @(posedge clk) begin
    if (state_r == ST_READ && k_r != 4'd0) begin
      for (int i = 0; i < PORT_BYTES - 1; i++) bytes_r[i] <= bytes_r[i + 1];
      bytes_r[PORT_BYTES - 1] <= rd_r;
    end
    if (state_r == ST_MUL1) begin
      negx_r <= sx[7];
      negy_r <= sy[7];
      px_r   <= 16'(magx) * 16'(sens_r);
      py_r   <= 16'(magy) * 16'(sens_r);
    end
    if (state_r == ST_MUL2) begin
      remx_r <= nx;
      remy_r <= ny;
      dzx_r  <= (nx <= 22'(dzlim_r));
      dzy_r  <= (ny <= 22'(dzlim_r));
    end
    if (state_r == ST_DIV) begin
      qx_r <= qpx[DIV_SHIFT +: 8];
      qy_r <= qpy[DIV_SHIFT +: 8];
    end
  end

  // key word
  assign cthr_s = signed'({2'b0, cthr_r});
  assign cx = 10'(signed'({~bytes_r[5][7], bytes_r[5][6:0]}));
  assign cy = 10'(signed'({~bytes_r[6][7], bytes_r[6][6:0]}));

  always_comb begin
    keys     = '0;
    keys[0]  = bytes_r[1][5];
    keys[1]  = bytes_r[1][4];
    keys[2]  = bytes_r[1][6];
    keys[3]  = bytes_r[1][7];
    keys[4]  = bytes_r[2][0];
    keys[5]  = bytes_r[2][1];
    keys[6]  = bytes_r[1][1];
    keys[7]  = bytes_r[1][0];
    keys[8]  = (cx > cthr_s);
    keys[9]  = (cx < -cthr_s);
    keys[10] = (cy < -cthr_s);
    keys[11] = (cy > cthr_s);
    keys[12] = (bytes_r[8] > tthr_r);
    keys[13] = (bytes_r[7] > tthr_r);
  end

  always_comb begin
    if (dzx_r)           ax = '0;
    else if (negx_r)     ax = (qx_r >= 8'd128) ? -8'sd128 : 8'(-qx_r);
    else                 ax = (qx_r >= 8'd128) ? 8'sd127 : signed'(qx_r);
    if (dzy_r)           ay = '0;
    else if (negy_r)     ay = (qy_r >= 8'd128) ? -8'sd128 : 8'(-qy_r);
    else                 ay = (qy_r >= 8'd128) ? 8'sd127 : signed'(qy_r);
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN) begin
      out_port_number  <= port_r;
      out_length_error <= bad_r;
      out_last_port    <= last_port;
      if (bad_r || bytes_r[0] == 8'd0) begin
        out_port_present    <= 1'b0;
        out_digital_buttons <= '0;
        out_x_axis          <= '0;
        out_y_axis          <= '0;
      end else begin
        out_port_present    <= 1'b1;
        out_digital_buttons <= keys;
        out_x_axis          <= ax;
        out_y_axis          <= ay;
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/gprk_checker.sv
// Port-level checks for the pad report mapper, bound to its top level.
`default_nettype none
module gprk_checker #(
  parameter int PORT_COUNT = gprk_pkg::PORT_COUNT_DEF
) (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [1:0]        out_port_number,
  input wire logic              out_port_present,
  input wire logic [15:0]       out_digital_buttons,
  input wire logic signed [7:0] out_x_axis,
  input wire logic signed [7:0] out_y_axis,
  input wire logic              out_length_error,
  input wire logic              out_last_port
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_port_number)
      && $stable(out_digital_buttons) && $stable(out_x_axis) && $stable(out_y_axis))
    else $error("key word changed while stalled");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("byte input open while a key word is pending");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_port == (out_port_number == 2'(PORT_COUNT - 1))))
    else $error("last port flag mismatch");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_length_error || !out_port_present) |->
      out_digital_buttons == 16'd0 && out_x_axis == 8'sd0 && out_y_axis == 8'sd0
      && !(out_length_error && out_port_present))
    else $error("absent or bad report gave nonzero keys");

  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_port |=> !in_ready)
    else $error("input reopened before final key word");

endmodule

bind gamepad_report_to_keys_mapper gprk_checker #(.PORT_COUNT(PORT_COUNT)) u_gprk_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_port_number     (out_port_number),
  .out_port_present    (out_port_present),
  .out_digital_buttons (out_digital_buttons),
  .out_x_axis          (out_x_axis),
  .out_y_axis          (out_y_axis),
  .out_length_error    (out_length_error),
  .out_last_port       (out_last_port)
);
`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the pad report to key word mapper, with prediction and random stalls.
`timescale 1ns / 1ps

module tb;
  import gprk_pkg::*;

  localparam int PORTS        = PORT_COUNT_DEF;
  localparam int DRAIN_CYCLES = 60;
  localparam int LIMIT_CYCLES = 300000;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [7:0] data;
    logic       eor;
  } report_byte_t;

  typedef struct {
    logic [1:0]        port;
    logic              present;
    logic [15:0]       buttons;
    logic signed [7:0] x;
    logic signed [7:0] y;
    logic              len_err;
    logic              last;
  } key_word_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        in_report_byte = 8'd0;
  logic              in_end_of_report = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = 2'd0;
  logic [7:0]        cfg_data = 8'd0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_port_number;
  logic              out_port_present;
  logic [15:0]       out_digital_buttons;
  logic signed [7:0] out_x_axis;
  logic signed [7:0] out_y_axis;
  logic              out_length_error;
  logic              out_last_port;

  gamepad_report_to_keys_mapper dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_report_byte      (in_report_byte),
    .in_end_of_report    (in_end_of_report),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_port_number     (out_port_number),
    .out_port_present    (out_port_present),
    .out_digital_buttons (out_digital_buttons),
    .out_x_axis          (out_x_axis),
    .out_y_axis          (out_y_axis),
    .out_length_error    (out_length_error),
    .out_last_port       (out_last_port)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [7:0] report_mem [STORE_DEPTH];
  int         byte_count = 0;
  logic [6:0] dz_pct = DZ_RESET;
  logic [7:0] sens_pct = SENS_RESET;
  logic [6:0] trig_pct = TRIG_RESET;
  logic [6:0] cst_pct = CST_RESET;

  report_byte_t byte_queue [$];
  key_word_t    key_words_due [$];
  report_byte_t pending;
  key_word_t    want;
  int           bytes_queued = 0;
  int           bytes_taken = 0;
  int           fail_count = 0;
  int           sender_idle_pct = 0;
  int           recv_stall_pct = 0;
  int unsigned  cycle_count = 0;
  int           hold_left = 0;
  logic         hold_arm = 1'b0;
  logic         hold_done = 1'b0;

  function automatic logic signed [7:0] scaled_axis(input logic [7:0] raw);
    int     s;
    int     mag;
    int     q;
    longint n;
    s = int'($signed(raw ^ 8'h80));
    mag = (s < 0) ? -s : s;
    n = longint'(mag) * AXIS_PEAK * longint'(sens_pct);
    if (n <= longint'(dz_pct) * DZ_SCALE) return 8'sd0;
    q = int'(n / AXIS_DIV);
    if (s < 0) return (q > 128) ? -8'sd128 : 8'(-q);
    return (q > 127) ? 8'sd127 : 8'(q);
  endfunction

  task automatic predict_byte(input logic [7:0] data, input logic eor);
    int         pos;
    int         tthr;
    int         cthr;
    int         cx;
    int         cy;
    int         base;
    logic [7:0] b1;
    logic [7:0] b2;
    key_word_t  kw;
    pos = byte_count;
    if (pos >= 1 && pos <= STORE_DEPTH) report_mem[pos - 1] = data;
    if (!eor) begin
      if (byte_count < CNT_MAX) byte_count++;
      return;
    end
    byte_count = 0;
    tthr = (127 * int'(trig_pct)) / 100;
    cthr = (127 * int'(cst_pct)) / 100;
    for (int p = 0; p < PORTS; p++) begin
      base = (p * PORT_BYTES) % STORE_DEPTH;
      kw.port = 2'(p);
      kw.present = 1'b0;
      kw.buttons = 16'd0;
      kw.x = 8'sd0;
      kw.y = 8'sd0;
      kw.len_err = (pos != REPORT_LEN - 1);
      kw.last = (p == PORTS - 1);
      if (!kw.len_err && report_mem[base] != 8'd0) begin
        b1 = report_mem[base + 1];
        b2 = report_mem[base + 2];
        cx = int'($signed(report_mem[base + 5] ^ 8'h80));
        cy = int'($signed(report_mem[base + 6] ^ 8'h80));
        kw.present = 1'b1;
        kw.buttons[0]  = b1[5];
        kw.buttons[1]  = b1[4];
        kw.buttons[2]  = b1[6];
        kw.buttons[3]  = b1[7];
        kw.buttons[4]  = b2[0];
        kw.buttons[5]  = b2[1];
        kw.buttons[6]  = b1[1];
        kw.buttons[7]  = b1[0];
        kw.buttons[8]  = (cx > cthr);
        kw.buttons[9]  = (cx < -cthr);
        kw.buttons[10] = (cy < -cthr);
        kw.buttons[11] = (cy > cthr);
        kw.buttons[12] = (int'(report_mem[base + 8]) > tthr);
        kw.buttons[13] = (int'(report_mem[base + 7]) > tthr);
        kw.x = scaled_axis(report_mem[base + 3]);
        kw.y = scaled_axis(report_mem[base + 4]);
      end
      key_words_due.push_back(kw);
    end
  endtask

  function automatic void check_field(input string name, input logic signed [16:0] exp_val,
                                      input logic signed [16:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      fail_count++;
    end
  endfunction

  // byte driver, prediction on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_byte(in_report_byte, in_end_of_report);
        bytes_taken++;
      end
      if (!in_valid || in_ready) begin
        if (byte_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          pending = byte_queue.pop_front();
          in_valid <= 1'b1;
          in_report_byte <= pending.data;
          in_end_of_report <= pending.eor;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_arm && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // key word checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (key_words_due.size() == 0) begin
          $error("key word for port %0d with none expected", out_port_number);
          fail_count++;
        end else begin
          want = key_words_due.pop_front();
          check_field("port_number", want.port, out_port_number);
          check_field("port_present", want.present, out_port_present);
          check_field("digital_buttons", want.buttons, out_digital_buttons);
          check_field("x_axis", want.x, out_x_axis);
          check_field("y_axis", want.y, out_y_axis);
          check_field("length_error", want.len_err, out_length_error);
          check_field("last_port", want.last, out_last_port);
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_report(input logic [7:0] bytes_in []);
    report_byte_t item;
    foreach (bytes_in[i]) begin
      item.data = bytes_in[i];
      item.eor = (i == bytes_in.size() - 1);
      byte_queue.push_back(item);
      bytes_queued++;
    end
  endtask

  function automatic logic [7:0] rand_stick();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      1: return 8'(8'h80 + $urandom_range(0, 40) - 20);
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic queue_random_report(input int len);
    logic [7:0] rpt [];
    int         slot;
    rpt = new[len];
    rpt[0] = 8'($urandom);
    for (int i = 1; i < len; i++) begin
      slot = (i - 1) % PORT_BYTES;
      if (slot == 0)
        rpt[i] = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
      else if (slot >= 3 && slot <= 6)
        rpt[i] = rand_stick();
      else
        rpt[i] = 8'($urandom);
    end
    send_report(rpt);
  endtask

  task automatic queue_reports(input int count, input int pct_broken);
    int len;
    for (int r = 0; r < count; r++) begin
      if ($urandom_range(0, 99) >= pct_broken)
        len = REPORT_LEN;
      else if ($urandom_range(0, 1) != 0)
        len = $urandom_range(1, REPORT_LEN - 1);
      else
        len = $urandom_range(REPORT_LEN + 1, 80);
      queue_random_report(len);
    end
  endtask

  task automatic drain();
    while (bytes_taken != bytes_queued || key_words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] dz, input logic [7:0] sens,
                                input logic [7:0] trig, input logic [7:0] cst);
    logic [7:0] vals [4];
    vals = '{dz, sens, trig, cst};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= gprk_reg_t'(i);
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      case (gprk_reg_t'(i))
        REG_DEADZONE:    dz_pct = vals[i][6:0];
        REG_SENSITIVITY: sens_pct = vals[i];
        REG_TRIGGER:     trig_pct = vals[i][6:0];
        REG_CSTICK:      cst_pct = vals[i][6:0];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [7:0] rpt [];
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: button extremes, thresholds and deadzone edges
    rpt = '{8'h3C,
            8'h14, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00,
            8'h00, 8'hA5, 8'hA5, 8'hA5, 8'hA5, 8'hA5, 8'hA5, 8'hA5, 8'hA5,
            8'h01, 8'h00, 8'h00, 8'h80, 8'h80, 8'hB2, 8'hB3, 8'h3F, 8'h40,
            8'hFF, 8'h55, 8'h02, 8'h91, 8'h6E, 8'h4E, 8'h4D, 8'h00, 8'hFE};
    send_report(rpt);
    rpt = '{8'hC3,
            8'h80, 8'h00, 8'hFC, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF,
            8'h02, 8'hAA, 8'hFD, 8'h7F, 8'h81, 8'h01, 8'hFE, 8'h40, 8'h3F,
            8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF,
            8'h7F, 8'h0F, 8'hF0, 8'h6F, 8'h92, 8'hB3, 8'h4C, 8'h80, 8'h7F};
    send_report(rpt);
    queue_random_report(1);
    queue_random_report(REPORT_LEN - 1);
    drain();

    apply_settings(8'd0, 8'd0, 8'd0, 8'd0);
    sender_idle_pct = 72;
    queue_reports(1, 20);
    drain();

    // bit 7 of the 7-bit registers is dropped
    apply_settings(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    sender_idle_pct = 0;
    recv_stall_pct = 72;
    queue_reports(1, 20);
    drain();

    apply_settings(8'd100, 8'd200, 8'd100, 8'd100);
    sender_idle_pct = 14;
    recv_stall_pct = 14;
    queue_reports(1, 0);
    drain();

    apply_settings(8'($urandom_range(0, 100)), 8'($urandom_range(0, 200)),
                   8'($urandom_range(0, 100)), 8'($urandom_range(0, 100)));
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    hold_arm <= 1'b1;
    queue_reports(2, 0);
    drain();

    // long report, counter saturates
    apply_settings(8'd0, 8'd1, 8'd0, 8'd0);
    sender_idle_pct = 14;
    recv_stall_pct = 14;
    queue_random_report(66);
    drain();

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
